FILE: src/euler_angles_to_basis_vectors_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the basis vector block
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_TOP_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_TOP_ASSERT_SVH

// check a property outside reset
`define EABV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("basis vector check failed");

// check a property at every edge, reset included
`define EABV_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("basis vector reset check failed");

`endif

FILE: src/eabv_pkg.sv
// ----------------------------------------------------------------------------
// eabv_pkg
// Types, constants and arithmetic helpers for the basis vector pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eabv_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;

   // Q30 fixed point
   localparam logic [30:0] Q30_ONE     = 31'd1 << 30;
   localparam logic [63:0] Q30_HALF    = 64'd1 << 29;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Horner steps of the sine series, k = 6 down to 1
   localparam int STEPS = 6;
   localparam logic [7:0]  DEN [STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   // reciprocal of DEN, scaled by 2^RECIP_SH
   localparam logic [31:0] RECIP_MUL [STEPS] = '{32'd3524075730, 32'd2498890063,
      32'd3817748707, 32'd3272356035, 32'd3435973836, 32'd2863311530};
   localparam int RECIP_SH [STEPS] = '{39, 38, 38, 37, 36, 34};

   // pipeline depths
   localparam int SINE_LAT  = 2 + 3 * STEPS + 1;
   localparam int TRIG_LAT  = SINE_LAT + 1;
   localparam int COMB_LAT  = 4;
   localparam int TOTAL_LAT = TRIG_LAT + COMB_LAT;

   // output rounding
   localparam int          ROUND_SH  = 30 - FRAC_BITS;
   localparam logic [33:0] ROUND_ADD = (34'd1 << ROUND_SH) >> 1;
   localparam logic [33:0] FIELD_LIM = 34'd1 << FRAC_BITS;

   typedef logic signed [31:0] trig_type;
   typedef logic signed [32:0] sum_type;

   typedef struct packed {
      logic [15:0] yaw_angle;
      logic [15:0] pitch_angle;
      logic [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   // Q30 x Q30 on magnitudes, round half away from zero
   function automatic trig_type mul_q30(input trig_type a, input trig_type b);
      logic        neg;
      logic [30:0] ma;
      logic [30:0] mb;
      logic [61:0] prod;
      logic [30:0] m;
      neg  = a[31] ^ b[31];
      ma   = 31'(a[31] ? -a : a);
      mb   = 31'(b[31] ? -b : b);
      prod = ma * mb;
      m    = 31'((64'(prod) + Q30_HALF) >> 30);
      return neg ? -trig_type'({1'b0, m}) : trig_type'({1'b0, m});
   endfunction

   // Q30 sum to output field: round half away from zero, saturate, truncate
   function automatic logic signed [15:0] to_field(input sum_type v);
      logic        neg;
      logic [33:0] mag;
      logic [33:0] m;
      neg = v[32];
      mag = 34'(v[32] ? -v : v);
      m   = (mag + ROUND_ADD) >> ROUND_SH;
      if (m > FIELD_LIM) begin
         m = FIELD_LIM;
      end
      return neg ? 16'(-m) : 16'(m);
   endfunction

endpackage

FILE: src/euler_angles_to_basis_vectors_top.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_top
// Throughput: one request per cycle; the whole pipe holds while the output
// register is valid and stalled, so req_stall follows rsp_stall then.
// Reset: synchronous, clears every stage valid bit; no payload is reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_angles_to_basis_vectors_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eabv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eabv_pkg::rsp_type rsp_data
);

   localparam int LAT = eabv_pkg::TOTAL_LAT;

   logic               en;
   logic [LAT-1:0]     vld_ff;
   logic [LAT-1:0]     vld_in;
   eabv_pkg::trig_type sy, cy, sp, cp, sr, cr;

   // advance unless a finished request waits at the output
   assign en        = ~(vld_ff[LAT-1] & rsp_stall);
   assign req_stall = reset | ~en;

   assign vld_in = {vld_ff[LAT-2:0], req_valid & ~req_stall};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   eabv_trig u_trig_yaw (
      .clock(clock), .en(en), .angle(req_data.yaw_angle), .sin_val(sy), .cos_val(cy)
   );
   eabv_trig u_trig_pitch (
      .clock(clock), .en(en), .angle(req_data.pitch_angle), .sin_val(sp), .cos_val(cp)
   );
   eabv_trig u_trig_roll (
      .clock(clock), .en(en), .angle(req_data.roll_angle), .sin_val(sr), .cos_val(cr)
   );

   eabv_combine u_combine (
      .clock(clock), .en(en),
      .sy(sy), .cy(cy), .sp(sp), .cp(cp), .sr(sr), .cr(cr),
      .result(rsp_data)
   );

   assign rsp_valid = vld_ff[LAT-1];

endmodule

FILE: src/eabv_sine.sv
// ----------------------------------------------------------------------------
// eabv_sine
// Pipelined quarter-turn sine: Horner series through x^13 in Q30, three
// stages per Horner step (multiply, reciprocal multiply, correction).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eabv_sine (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] r,
   output logic [30:0] sine
);

   localparam int N = eabv_pkg::STEPS;

   logic [61:0] rx;
   logic [30:0] x_ff;
   logic [30:0] x_in;
   logic [61:0] xx;
   logic [31:0] x2_ff;
   logic [31:0] x2_in;
   logic [30:0] xs_ff;

   logic [31:0] p_ff  [N];
   logic [31:0] pb_ff [N];
   logic [31:0] q0_ff [N];
   logic [31:0] x2a_ff[N];
   logic [31:0] x2b_ff[N];
   logic [31:0] x2c_ff[N];
   logic [30:0] xa_ff [N];
   logic [30:0] xb_ff [N];
   logic [30:0] xc_ff [N];
   logic [30:0] t_ff  [N];

   logic [61:0] xt;
   logic [31:0] s_raw;
   logic [30:0] sine_ff;
   logic [30:0] sine_in;

   // scale the quarter-turn fraction to radians
   assign rx   = r * eabv_pkg::HALF_PI_Q30;
   assign x_in = 31'((64'(rx) + eabv_pkg::Q30_HALF) >> 30);

   // square of the angle
   assign xx    = x_ff * x_ff;
   assign x2_in = 32'((64'(xx) + eabv_pkg::Q30_HALF) >> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         x2_ff <= x2_in;
         xs_ff <= x_ff;
      end
   end

   // Horner steps: t = 1 - x^2 * t / den
   for (genvar i = 0; i < N; i++) begin : g_step
      logic [30:0] t_src;
      logic [30:0] x_src;
      logic [31:0] x2_src;
      logic [62:0] pt;
      logic [31:0] p_in;
      logic [63:0] pm;
      logic [31:0] q0_in;
      logic [39:0] qd;
      logic [39:0] rem;
      logic [31:0] q;
      logic [30:0] t_in;

      if (i == 0) begin : g_first
         assign t_src  = eabv_pkg::Q30_ONE;
         assign x_src  = xs_ff;
         assign x2_src = x2_ff;
      end else begin : g_next
         assign t_src  = t_ff[i-1];
         assign x_src  = xc_ff[i-1];
         assign x2_src = x2c_ff[i-1];
      end

      // multiply by x^2
      assign pt   = x2_src * t_src;
      assign p_in = 32'((64'(pt) + eabv_pkg::Q30_HALF) >> 30);

      // quotient estimate by reciprocal, low by at most one
      assign pm    = p_ff[i] * eabv_pkg::RECIP_MUL[i];
      assign q0_in = 32'(pm >> eabv_pkg::RECIP_SH[i]);

      // correct the estimate and form the next term
      assign qd   = 40'(q0_ff[i]) * 40'(eabv_pkg::DEN[i]);
      assign rem  = 40'(pb_ff[i]) - qd;
      assign q    = (rem >= 40'(eabv_pkg::DEN[i])) ? q0_ff[i] + 32'd1 : q0_ff[i];
      assign t_in = 31'(32'(eabv_pkg::Q30_ONE) - q);

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[i]   <= p_in;
            xa_ff[i]  <= x_src;
            x2a_ff[i] <= x2_src;
            q0_ff[i]  <= q0_in;
            pb_ff[i]  <= p_ff[i];
            xb_ff[i]  <= xa_ff[i];
            x2b_ff[i] <= x2a_ff[i];
            t_ff[i]   <= t_in;
            xc_ff[i]  <= xb_ff[i];
            x2c_ff[i] <= x2b_ff[i];
         end
      end
   end

   // final multiply by x and clamp to one
   assign xt      = xc_ff[N-1] * t_ff[N-1];
   assign s_raw   = 32'((64'(xt) + eabv_pkg::Q30_HALF) >> 30);
   assign sine_in = (s_raw > 32'(eabv_pkg::Q30_ONE)) ? eabv_pkg::Q30_ONE : 31'(s_raw);

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

FILE: src/eabv_trig.sv
// ----------------------------------------------------------------------------
// eabv_trig
// Sine and cosine of one binary angle: two quarter sines and quadrant signs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eabv_trig (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output eabv_pkg::trig_type sin_val,
   output eabv_pkg::trig_type cos_val
);

   localparam int LAT      = eabv_pkg::SINE_LAT;
   localparam int PHASE_SH = 32 - eabv_pkg::ANGLE_BITS;

   logic [31:0]        masked;
   logic [31:0]        phase;
   logic [30:0]        r_lo;
   logic [30:0]        r_hi;
   logic [30:0]        a;
   logic [30:0]        b;
   logic [1:0]         quad_ff [LAT];
   eabv_pkg::trig_type sa;
   eabv_pkg::trig_type sb;
   eabv_pkg::trig_type sin_ff;
   eabv_pkg::trig_type cos_ff;
   eabv_pkg::trig_type sin_in;
   eabv_pkg::trig_type cos_in;

   // split the angle into quadrant and fraction of a quarter turn
   assign masked = 32'(angle) & ((32'd1 << eabv_pkg::ANGLE_BITS) - 32'd1);
   assign phase  = masked << PHASE_SH;
   assign r_lo   = {1'b0, phase[29:0]};
   assign r_hi   = eabv_pkg::Q30_ONE - r_lo;

   eabv_sine u_sine_lo (.clock(clock), .en(en), .r(r_lo), .sine(a));
   eabv_sine u_sine_hi (.clock(clock), .en(en), .r(r_hi), .sine(b));

   // carry the quadrant alongside the sine pipes
   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= phase[31:30];
         for (int k = 1; k < LAT; k++) begin
            quad_ff[k] <= quad_ff[k-1];
         end
      end
   end

   // apply quadrant symmetry
   assign sa = eabv_pkg::trig_type'({1'b0, a});
   assign sb = eabv_pkg::trig_type'({1'b0, b});

   always_comb begin
      case (quad_ff[LAT-1])
         2'd0: begin
            sin_in = sa;
            cos_in = sb;
         end
         2'd1: begin
            sin_in = sb;
            cos_in = -sa;
         end
         2'd2: begin
            sin_in = -sa;
            cos_in = -sb;
         end
         default: begin
            sin_in = -sb;
            cos_in = sa;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

FILE: src/eabv_combine.sv
// ----------------------------------------------------------------------------
// eabv_combine
// Products and sums of sines and cosines into the nine vector components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eabv_combine (
   input  logic               clock,
   input  logic               en,
   input  eabv_pkg::trig_type sy,
   input  eabv_pkg::trig_type cy,
   input  eabv_pkg::trig_type sp,
   input  eabv_pkg::trig_type cp,
   input  eabv_pkg::trig_type sr,
   input  eabv_pkg::trig_type cr,
   output eabv_pkg::rsp_type  result
);

   // first product stage
   eabv_pkg::trig_type spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   eabv_pkg::trig_type crsy_ff, crcy_ff, srsy_ff, srcy_ff, sp_ff, sr_ff, cr_ff;
   // second product stage
   eabv_pkg::trig_type srspcy_ff, crspcy_ff, srspsy_ff, crspsy_ff;
   eabv_pkg::trig_type cpcy2_ff, cpsy2_ff, srcp2_ff, crcp2_ff;
   eabv_pkg::trig_type crsy2_ff, crcy2_ff, srsy2_ff, srcy2_ff, sp2_ff;
   // sum stage
   eabv_pkg::sum_type  fx_ff, fy_ff, fz_ff, rx_ff, ry_ff, rz_ff, ux_ff, uy_ff, uz_ff;
   eabv_pkg::rsp_type  result_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         // single products
         spcy_ff <= eabv_pkg::mul_q30(sp, cy);
         spsy_ff <= eabv_pkg::mul_q30(sp, sy);
         cpcy_ff <= eabv_pkg::mul_q30(cp, cy);
         cpsy_ff <= eabv_pkg::mul_q30(cp, sy);
         srcp_ff <= eabv_pkg::mul_q30(sr, cp);
         crcp_ff <= eabv_pkg::mul_q30(cr, cp);
         crsy_ff <= eabv_pkg::mul_q30(cr, sy);
         crcy_ff <= eabv_pkg::mul_q30(cr, cy);
         srsy_ff <= eabv_pkg::mul_q30(sr, sy);
         srcy_ff <= eabv_pkg::mul_q30(sr, cy);
         sp_ff   <= sp;
         sr_ff   <= sr;
         cr_ff   <= cr;

         // triple products, hold the rest
         srspcy_ff <= eabv_pkg::mul_q30(sr_ff, spcy_ff);
         crspcy_ff <= eabv_pkg::mul_q30(cr_ff, spcy_ff);
         srspsy_ff <= eabv_pkg::mul_q30(sr_ff, spsy_ff);
         crspsy_ff <= eabv_pkg::mul_q30(cr_ff, spsy_ff);
         cpcy2_ff  <= cpcy_ff;
         cpsy2_ff  <= cpsy_ff;
         srcp2_ff  <= srcp_ff;
         crcp2_ff  <= crcp_ff;
         crsy2_ff  <= crsy_ff;
         crcy2_ff  <= crcy_ff;
         srsy2_ff  <= srsy_ff;
         srcy2_ff  <= srcy_ff;
         sp2_ff    <= sp_ff;

         // component sums
         fx_ff <= 33'(cpcy2_ff);
         fy_ff <= 33'(cpsy2_ff);
         fz_ff <= -33'(sp2_ff);
         rx_ff <= 33'(crsy2_ff) - 33'(srspcy_ff);
         ry_ff <= -33'(srspsy_ff) - 33'(crcy2_ff);
         rz_ff <= -33'(srcp2_ff);
         ux_ff <= 33'(crspcy_ff) + 33'(srsy2_ff);
         uy_ff <= 33'(crspsy_ff) - 33'(srcy2_ff);
         uz_ff <= 33'(crcp2_ff);

         // round and saturate
         result_ff.fwd_x   <= eabv_pkg::to_field(fx_ff);
         result_ff.fwd_y   <= eabv_pkg::to_field(fy_ff);
         result_ff.fwd_z   <= eabv_pkg::to_field(fz_ff);
         result_ff.right_x <= eabv_pkg::to_field(rx_ff);
         result_ff.right_y <= eabv_pkg::to_field(ry_ff);
         result_ff.right_z <= eabv_pkg::to_field(rz_ff);
         result_ff.up_x    <= eabv_pkg::to_field(ux_ff);
         result_ff.up_y    <= eabv_pkg::to_field(uy_ff);
         result_ff.up_z    <= eabv_pkg::to_field(uz_ff);
      end
   end

   assign result = result_ff;

endmodule

FILE: src/eabv_checker.sv
// ----------------------------------------------------------------------------
// eabv_checker
// Port-level checks on the basis vector block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_top_assert.svh"

module eabv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input eabv_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input eabv_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic req_held;
   logic fz_ok;
   logic uz_ok;

   // handshake states and component bounds
   assign rsp_held = rsp_valid && rsp_stall;
   assign req_held = req_valid && req_stall;
   assign fz_ok    = (rsp_data.fwd_z >= -16'sd16384) && (rsp_data.fwd_z <= 16'sd16384);
   assign uz_ok    = (rsp_data.up_z >= -16'sd16384) && (rsp_data.up_z <= 16'sd16384);

   // a stalled response holds
   `EABV_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_data))

   // a stalled request holds
   `EABV_ASSERT(a_req_hold, clock, reset, req_held |=> req_valid && $stable(req_data))

   // the request side stalls only behind a held response
   `EABV_ASSERT(a_req_stall, clock, reset, req_stall == rsp_held)

   // the forward and up z components stay within one unit
   `EABV_ASSERT(a_range, clock, reset, rsp_valid |-> fz_ok && uz_ok)

   // reset empties the pipe
   `EABV_ASSERT_NR(a_reset, clock, reset |=> !rsp_valid)

endmodule

bind euler_angles_to_basis_vectors_top eabv_checker u_eabv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Basis vector block testbench
// Drives angle triples through the valid/stall request channel, predicts the
// forward, right and up vectors in fixed point and checks every response in
// order, under several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// predicted vectors awaiting their responses
class basis_scoreboard;
   eabv_pkg::rsp_type pending[$];
   int                errors;

   // sine of a Q30 fraction of a quarter turn
   static function longint quarter_sin(longint unsigned r);
      longint unsigned x, x2, t, s, den;
      x  = (r * 64'd1686629713 + 64'd536870912) >> 30;
      x2 = (x * x + 64'd536870912) >> 30;
      t  = 64'd1 << 30;
      for (int k = 6; k >= 1; k--) begin
         den = longint'(2 * k) * longint'(2 * k + 1);
         t   = (64'd1 << 30) - ((x2 * t + 64'd536870912) >> 30) / den;
      end
      s = (x * t + 64'd536870912) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      return longint'(s);
   endfunction

   static function void trig(logic [15:0] ang, output longint sn, output longint cs);
      longint unsigned phase, r;
      longint a, b;
      phase = longint'(ang) << 16;
      r     = phase & ((64'd1 << 30) - 1);
      a     = quarter_sin(r);
      b     = quarter_sin((64'd1 << 30) - r);
      case (phase[31:30])
         2'd0: begin sn = a;  cs = b;  end
         2'd1: begin sn = b;  cs = -a; end
         2'd2: begin sn = -a; cs = -b; end
         default: begin sn = -b; cs = a; end
      endcase
   endfunction

   static function longint qmul(longint a, longint b);
      longint unsigned ma, mb, m;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m  = (ma * mb + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   static function logic signed [15:0] quantize(longint v);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m = (m + 64'd32768) >> 16;
      if (m > 64'd16384) m = 64'd16384;
      return v < 0 ? 16'(-m) : 16'(m);
   endfunction

   // note an accepted request
   function void note_request(eabv_pkg::req_type rq);
      longint sy, cy, sp, cp, sr, cr, spcy, spsy;
      eabv_pkg::rsp_type e;
      trig(rq.yaw_angle, sy, cy);
      trig(rq.pitch_angle, sp, cp);
      trig(rq.roll_angle, sr, cr);
      spcy = qmul(sp, cy);
      spsy = qmul(sp, sy);
      e.fwd_x   = quantize(qmul(cp, cy));
      e.fwd_y   = quantize(qmul(cp, sy));
      e.fwd_z   = quantize(-sp);
      e.right_x = quantize(-qmul(sr, spcy) + qmul(cr, sy));
      e.right_y = quantize(-qmul(sr, spsy) - qmul(cr, cy));
      e.right_z = quantize(-qmul(sr, cp));
      e.up_x    = quantize(qmul(cr, spcy) + qmul(sr, sy));
      e.up_y    = quantize(qmul(cr, spsy) - qmul(sr, cy));
      e.up_z    = quantize(qmul(cr, cp));
      pending.push_back(e);
   endfunction

   // check one accepted response against the oldest prediction
   function void check_response(eabv_pkg::rsp_type got);
      eabv_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.fwd_x !== e.fwd_x) report("fwd_x", e.fwd_x, got.fwd_x);
      if (got.fwd_y !== e.fwd_y) report("fwd_y", e.fwd_y, got.fwd_y);
      if (got.fwd_z !== e.fwd_z) report("fwd_z", e.fwd_z, got.fwd_z);
      if (got.right_x !== e.right_x) report("right_x", e.right_x, got.right_x);
      if (got.right_y !== e.right_y) report("right_y", e.right_y, got.right_y);
      if (got.right_z !== e.right_z) report("right_z", e.right_z, got.right_z);
      if (got.up_x !== e.up_x) report("up_x", e.up_x, got.up_x);
      if (got.up_y !== e.up_y) report("up_y", e.up_y, got.up_y);
      if (got.up_z !== e.up_z) report("up_z", e.up_z, got.up_z);
   endfunction

   function void report(string fld, logic signed [15:0] e, logic signed [15:0] a);
      $display("%0t: %s expected %0d actual %0d", $time, fld, e, a);
      errors++;
   endfunction
endclass

module tb;
   localparam int WATCHDOG = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   eabv_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   eabv_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   basis_scoreboard vectors = new();

   euler_angles_to_basis_vectors_top u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // randomize the receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // score accepted requests and responses; watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) vectors.note_request(req_data);
         if (rsp_valid && !rsp_stall) vectors.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else if (!stim_done || vectors.pending.size() != 0) idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // send one request, idling first at random, and hold until accepted
   task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{yaw_angle: yaw, pitch_angle: pitch, roll_angle: roll};
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(3))
         0: return 16'($urandom_range(3)) << 14;
         1: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] edges[] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
         16'h0001, 16'h3FFF, 16'h2000};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: quadrant boundaries and extremes on each axis
      foreach (edges[i]) send_angles(edges[i], 16'h0000, 16'h0000);
      foreach (edges[i]) send_angles(16'h0000, edges[i], 16'h0000);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_angles(16'h5555, 16'hAAAA, 16'h1234);
      foreach (edges[i]) send_angles(16'h1000, 16'h3000, edges[i]);

      // random phases of idling and stalling
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3: begin send_idle_pct = 15; recv_stall_pct = 15; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (106) send_angles(rand_angle(), rand_angle(), rand_angle());
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;

      // drain, then allow for the pipeline depth
      while (vectors.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (vectors.errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+src
src/eabv_pkg.sv
src/eabv_sine.sv
src/eabv_trig.sv
src/eabv_combine.sv
src/euler_angles_to_basis_vectors_top.sv
src/eabv_checker.sv
verif/tb.sv
